// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files of the modular exponentiation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== src/rsamx_pkg.sv =====
`default_nettype none

package rsamx_pkg;

	localparam int unsigned VALUE_W       = 32;
	localparam int unsigned EXP_W         = 32;
	localparam int unsigned PRIME_W       = 16;
	localparam int unsigned CFG_W         = 32;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned MOD_WIDTH_DEF = 32;

	localparam int unsigned MM_CNT_W  = $clog2(VALUE_W + 1);
	localparam int unsigned EXP_CNT_W = $clog2(EXP_W + 1);
	localparam int unsigned DIV_CNT_W = $clog2(PRIME_W + 1);
	// Signed width of the Bezout coefficients, with headroom for the partial products.
	localparam int unsigned INV_TW    = PRIME_W + 3;

	localparam logic [CFG_W-1:0]   MODULUS_RST     = 32'd3233;
	localparam logic [EXP_W-1:0]   PUB_EXP_RST     = 32'd17;
	localparam logic [EXP_W-1:0]   PRIV_EXP_RST    = 32'd2753;
	localparam logic [PRIME_W-1:0] PRIME_FIRST_RST = 16'd61;
	localparam logic [PRIME_W-1:0] PRIME_SECOND_RST = 16'd53;

	typedef enum logic [1:0] {
		MODE_ENC = 2'd0,
		MODE_DEC = 2'd1,
		MODE_CRT = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS      = 3'd0,
		CFG_PUB_EXP      = 3'd1,
		CFG_PRIV_EXP     = 3'd2,
		CFG_PRIME_FIRST  = 3'd3,
		CFG_PRIME_SECOND = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic               done;
		logic               ok;
		logic [PRIME_W-1:0] inv;
	} inv_rsp_t;

endpackage

`default_nettype wire

// ===== src/rsamx_modmul.sv =====
`default_nettype none

// Bit-serial interleaved modular multiplier: r = (x * y) mod m, one bit of x per cycle,
// most significant bit first. Needs y < m. With y = 1 it reduces x modulo m.
module rsamx_modmul import rsamx_pkg::*; #(
	parameter int unsigned MW = MOD_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic [VALUE_W-1:0] x,
	input  wire logic [MW-1:0]      y,
	input  wire logic [MW-1:0]      m,
	output logic                    done,
	output logic [MW-1:0]           r
);

	logic                busy_q;
	logic                done_q;
	logic [MM_CNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0]  x_q;
	logic [MW-1:0]       y_q;
	logic [MW-1:0]       m_q;
	logic [MW-1:0]       acc_q;

	logic [MW:0] dbl;
	logic [MW:0] dbl_red;
	logic [MW:0] sum;
	logic [MW:0] sum_red;

	// Doubling and adding each stay below twice the modulus, so one subtract apiece.
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = {1'b0, dbl_red[MW-1:0]} + (x_q[VALUE_W-1] ? {1'b0, y_q} : '0);
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= MM_CNT_W'(VALUE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MM_CNT_W'(1);
				if (cnt_q == MM_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[VALUE_W-2:0], 1'b0};
			acc_q <= sum_red[MW-1:0];
		end
	end

	assign done = done_q;
	assign r    = acc_q;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_go_while_busy, clk, arst_n, go && busy_q, "modmul started while busy")
	`ASSERT_PROP(a_acc_reduced, clk, arst_n, busy_q |-> (acc_q < m_q), "partial product not reduced")
	`ASSERT_PROP(a_result_reduced, clk, arst_n, done_q |-> (acc_q < m_q), "product not below modulus")

endmodule

`default_nettype wire

// ===== src/rsamx_inv.sv =====
`default_nettype none

// Modular inverse of a modulo m by the extended Euclidean algorithm. Each quotient is found
// by a bit-serial restoring division, and the coefficient product is built alongside it
// from the quotient bits as they appear.
module rsamx_inv import rsamx_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic [PRIME_W-1:0] a,
	input  wire logic [PRIME_W-1:0] m,
	output inv_rsp_t                rsp
);

	typedef enum logic [2:0] {
		INV_IDLE  = 3'b001,
		INV_CHECK = 3'b010,
		INV_DIV   = 3'b100
	} inv_state_t;

	inv_state_t                 state_q;
	logic [PRIME_W-1:0]         r0_q;
	logic [PRIME_W-1:0]         r1_q;
	logic signed [INV_TW-1:0]   t0_q;
	logic signed [INV_TW-1:0]   t1_q;
	logic [PRIME_W-1:0]         rem_q;
	logic [PRIME_W-1:0]         dvd_q;
	logic signed [INV_TW-1:0]   prod_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic [PRIME_W-1:0]         m_q;
	inv_rsp_t                   rsp_q;

	logic [PRIME_W:0]           rr;
	logic                       ge;
	logic [PRIME_W:0]           rem_nx;
	logic signed [INV_TW-1:0]   prod_nx;
	logic signed [INV_TW-1:0]   m_ext;
	logic signed [INV_TW-1:0]   t_fix;

	always_comb begin
		rr      = {rem_q, dvd_q[PRIME_W-1]};
		ge      = (rr >= {1'b0, r1_q});
		rem_nx  = ge ? rr - {1'b0, r1_q} : rr;
		prod_nx = (prod_q <<< 1) + (ge ? t1_q : '0);
		m_ext   = $signed({{(INV_TW - PRIME_W){1'b0}}, m_q});
		t_fix   = t0_q[INV_TW-1] ? t0_q + m_ext : t0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INV_IDLE;
			r0_q    <= '0;
			r1_q    <= '0;
			t0_q    <= '0;
			t1_q    <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			prod_q  <= '0;
			cnt_q   <= '0;
			m_q     <= '0;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			case (state_q)
				INV_IDLE: begin
					if (go) begin
						r0_q    <= m;
						r1_q    <= a;
						t0_q    <= '0;
						t1_q    <= INV_TW'(1);
						m_q     <= m;
						state_q <= INV_CHECK;
					end
				end
				INV_CHECK: begin
					if (r1_q == '0) begin
						rsp_q.done <= 1'b1;
						rsp_q.ok   <= (r0_q == PRIME_W'(1));
						rsp_q.inv  <= t_fix[PRIME_W-1:0];
						state_q    <= INV_IDLE;
					end else begin
						rem_q   <= '0;
						dvd_q   <= r0_q;
						prod_q  <= '0;
						cnt_q   <= DIV_CNT_W'(PRIME_W);
						state_q <= INV_DIV;
					end
				end
				INV_DIV: begin
					rem_q  <= rem_nx[PRIME_W-1:0];
					dvd_q  <= {dvd_q[PRIME_W-2:0], 1'b0};
					prod_q <= prod_nx;
					cnt_q  <= cnt_q - DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(1)) begin
						r0_q    <= r1_q;
						r1_q    <= rem_nx[PRIME_W-1:0];
						t0_q    <= t1_q;
						t1_q    <= t0_q - prod_nx;
						state_q <= INV_CHECK;
					end
				end
				default: state_q <= INV_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;

`include "assert_macros.svh"

	`ASSERT_PROP(a_inv_in_range, clk, arst_n, rsp_q.done |-> (!rsp_q.ok || (rsp_q.inv < m_q)), "inverse not reduced")

endmodule

`default_nettype wire

// ===== src/rsa_modexp_crt_unit_top.sv =====
`default_nettype none

// RSA modular exponentiation unit. A word carries a value and a mode (encrypt with the
// public exponent, direct decrypt with the private exponent, or decrypt through the Chinese
// remainder theorem with the two primes) and gives one result word; the no-inverse flag
// marks a CRT decrypt with a prime below two, or whose second prime has no inverse modulo
// the first, with result 0. One word is processed at a time; the next is taken as soon as
// the previous result sits in the output register. The modular products run through one
// bit-serial modular multiplier. An exponentiation takes a base reduction, a scan past the
// leading zeros of the exponent, then a squaring for each further exponent bit plus a
// multiplication for every set bit. CRT decrypt adds four reductions and one further
// product, the Euclidean inverse and two exponentiations modulo the 16-bit primes, whose
// reduced exponents have at most 16 bits. Configuration must be written by the user only
// while the unit is idle; the block itself does not enforce it.
module rsa_modexp_crt_unit_top import rsamx_pkg::*; #(
	parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [VALUE_W-1:0]   s_axis_tdata,  // value
	input  wire logic [1:0]           s_axis_tuser,  // mode
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [VALUE_W-1:0]        m_axis_tdata,  // result
	output logic                      m_axis_tuser,  // no_inverse
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int unsigned MW = (MOD_WIDTH > PRIME_W) ? MOD_WIDTH : PRIME_W;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_DISP   = 17'h00002,
		S_RQ     = 17'h00004,
		S_INV    = 17'h00008,
		S_RDP    = 17'h00010,
		S_RDQ    = 17'h00020,
		S_PSTART = 17'h00040,
		S_RBASE  = 17'h00080,
		S_SCAN   = 17'h00100,
		S_NEXT   = 17'h00200,
		S_SQ     = 17'h00400,
		S_MUL    = 17'h00800,
		S_PDONE  = 17'h01000,
		S_RM2    = 17'h02000,
		S_HMUL   = 17'h04000,
		S_ADD    = 17'h08000,
		S_FIN    = 17'h10000
	} state_t;

	// Configuration registers.
	logic [MOD_WIDTH-1:0] modulus_q;
	logic [EXP_W-1:0]     pub_exp_q;
	logic [EXP_W-1:0]     priv_exp_q;
	logic [PRIME_W-1:0]   prime_first_q;
	logic [PRIME_W-1:0]   prime_second_q;

	state_t               state_q;
	mode_t                mode_q;
	logic [VALUE_W-1:0]   val_q;
	logic [VALUE_W-1:0]   res_q;
	logic                 flag_q;
	logic                 crt2_q;
	logic [MW-1:0]        mod_q;
	logic [EXP_W-1:0]     exp_q;
	logic [EXP_CNT_W-1:0] bitcnt_q;
	logic [MW-1:0]        base_q;
	logic [MW-1:0]        acc_q;
	logic [PRIME_W-1:0]   m1_q;
	logic [PRIME_W-1:0]   m2_q;
	logic [PRIME_W-1:0]   qinv_q;
	logic [PRIME_W-1:0]   dp_q;
	logic [PRIME_W-1:0]   dq_q;
	logic [VALUE_W-1:0]   prod_q;

	logic                 mm_go_q;
	logic [VALUE_W-1:0]   mm_x_q;
	logic [MW-1:0]        mm_y_q;
	logic [MW-1:0]        mm_m_q;
	logic                 mm_done;
	logic [MW-1:0]        mm_r;

	logic                 inv_go_q;
	logic [PRIME_W-1:0]   inv_a_q;
	inv_rsp_t             inv_rsp;

	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_data_q;
	logic                 out_flag_q;

	logic [PRIME_W-1:0]   m2_red;
	logic [PRIME_W:0]     diff_wide;

	rsamx_modmul #(
		.MW(MW)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mm_go_q),
		.x      (mm_x_q),
		.y      (mm_y_q),
		.m      (mm_m_q),
		.done   (mm_done),
		.r      (mm_r)
	);

	rsamx_inv u_inv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (inv_go_q),
		.a      (inv_a_q),
		.m      (prime_first_q),
		.rsp    (inv_rsp)
	);

	// (m1 - m2) modulo p, with m2 already reduced modulo p by the multiplier.
	always_comb begin
		m2_red    = mm_r[PRIME_W-1:0];
		diff_wide = (m1_q >= m2_red) ? {1'b0, m1_q} - {1'b0, m2_red}
		                             : {1'b0, m1_q} + {1'b0, prime_first_q} - {1'b0, m2_red};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q      <= MOD_WIDTH'(MODULUS_RST);
			pub_exp_q      <= PUB_EXP_RST;
			priv_exp_q     <= PRIV_EXP_RST;
			prime_first_q  <= PRIME_FIRST_RST;
			prime_second_q <= PRIME_SECOND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MODULUS:      modulus_q      <= cfg_data[MOD_WIDTH-1:0];
				CFG_PUB_EXP:      pub_exp_q      <= cfg_data[EXP_W-1:0];
				CFG_PRIV_EXP:     priv_exp_q     <= cfg_data[EXP_W-1:0];
				CFG_PRIME_FIRST:  prime_first_q  <= cfg_data[PRIME_W-1:0];
				CFG_PRIME_SECOND: prime_second_q <= cfg_data[PRIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_ENC;
			val_q       <= '0;
			res_q       <= '0;
			flag_q      <= 1'b0;
			crt2_q      <= 1'b0;
			mod_q       <= '0;
			exp_q       <= '0;
			bitcnt_q    <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			m1_q        <= '0;
			m2_q        <= '0;
			qinv_q      <= '0;
			dp_q        <= '0;
			dq_q        <= '0;
			prod_q      <= '0;
			mm_go_q     <= 1'b0;
			mm_x_q      <= '0;
			mm_y_q      <= '0;
			mm_m_q      <= '0;
			inv_go_q    <= 1'b0;
			inv_a_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_flag_q  <= 1'b0;
		end else begin
			mm_go_q  <= 1'b0;
			inv_go_q <= 1'b0;
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q  <= mode_t'(s_axis_tuser);
						val_q   <= s_axis_tdata;
						res_q   <= '0;
						flag_q  <= 1'b0;
						crt2_q  <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (mode_q)
						MODE_ENC: begin
							if (pub_exp_q == '0) begin
								res_q   <= VALUE_W'(1);
								state_q <= S_FIN;
							end else if (modulus_q == '0) begin
								state_q <= S_FIN;
							end else begin
								mod_q   <= MW'(modulus_q);
								exp_q   <= pub_exp_q;
								state_q <= S_PSTART;
							end
						end
						MODE_DEC: begin
							if (val_q == '0) begin
								state_q <= S_FIN;
							end else if (priv_exp_q == '0) begin
								res_q   <= VALUE_W'(1);
								state_q <= S_FIN;
							end else if (modulus_q == '0) begin
								state_q <= S_FIN;
							end else begin
								mod_q   <= MW'(modulus_q);
								exp_q   <= priv_exp_q;
								state_q <= S_PSTART;
							end
						end
						MODE_CRT: begin
							if (val_q == '0) begin
								state_q <= S_FIN;
							end else if (prime_first_q < PRIME_W'(2)
							             || prime_second_q < PRIME_W'(2)) begin
								flag_q  <= 1'b1;
								state_q <= S_FIN;
							end else begin
								mm_go_q <= 1'b1;
								mm_x_q  <= VALUE_W'(prime_second_q);
								mm_y_q  <= MW'(1);
								mm_m_q  <= MW'(prime_first_q);
								state_q <= S_RQ;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_RQ: begin
					if (mm_done) begin
						inv_go_q <= 1'b1;
						inv_a_q  <= mm_r[PRIME_W-1:0];
						state_q  <= S_INV;
					end
				end
				S_INV: begin
					if (inv_rsp.done) begin
						if (!inv_rsp.ok) begin
							flag_q  <= 1'b1;
							state_q <= S_FIN;
						end else begin
							qinv_q  <= inv_rsp.inv;
							mm_go_q <= 1'b1;
							mm_x_q  <= VALUE_W'(priv_exp_q);
							mm_y_q  <= MW'(prime_first_q != PRIME_W'(2));
							mm_m_q  <= MW'(prime_first_q - PRIME_W'(1));
							state_q <= S_RDP;
						end
					end
				end
				S_RDP: begin
					if (mm_done) begin
						dp_q    <= mm_r[PRIME_W-1:0];
						mm_go_q <= 1'b1;
						mm_x_q  <= VALUE_W'(priv_exp_q);
						mm_y_q  <= MW'(prime_second_q != PRIME_W'(2));
						mm_m_q  <= MW'(prime_second_q - PRIME_W'(1));
						state_q <= S_RDQ;
					end
				end
				S_RDQ: begin
					if (mm_done) begin
						dq_q    <= mm_r[PRIME_W-1:0];
						mod_q   <= MW'(prime_first_q);
						exp_q   <= EXP_W'(dp_q);
						state_q <= S_PSTART;
					end
				end
				S_PSTART: begin
					// Base reduction; a modulus of one leaves nothing but zero.
					mm_go_q  <= 1'b1;
					mm_x_q   <= val_q;
					mm_y_q   <= MW'(mod_q != MW'(1));
					mm_m_q   <= mod_q;
					bitcnt_q <= '0;
					state_q  <= S_RBASE;
				end
				S_RBASE: begin
					if (mm_done) begin
						base_q  <= mm_r;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Skip leading zeros; the first set bit loads the base directly.
					if (exp_q[EXP_W-1]) begin
						acc_q    <= base_q;
						exp_q    <= {exp_q[EXP_W-2:0], 1'b0};
						bitcnt_q <= bitcnt_q + EXP_CNT_W'(1);
						state_q  <= S_NEXT;
					end else if (exp_q == '0) begin
						acc_q   <= MW'(1);
						state_q <= S_PDONE;
					end else begin
						exp_q    <= {exp_q[EXP_W-2:0], 1'b0};
						bitcnt_q <= bitcnt_q + EXP_CNT_W'(1);
					end
				end
				S_NEXT: begin
					if (bitcnt_q == EXP_CNT_W'(EXP_W)) begin
						state_q <= S_PDONE;
					end else begin
						mm_go_q <= 1'b1;
						mm_x_q  <= VALUE_W'(acc_q);
						mm_y_q  <= acc_q;
						mm_m_q  <= mod_q;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (mm_done) begin
						acc_q    <= mm_r;
						exp_q    <= {exp_q[EXP_W-2:0], 1'b0};
						bitcnt_q <= bitcnt_q + EXP_CNT_W'(1);
						if (exp_q[EXP_W-1]) begin
							mm_go_q <= 1'b1;
							mm_x_q  <= VALUE_W'(mm_r);
							mm_y_q  <= base_q;
							mm_m_q  <= mod_q;
							state_q <= S_MUL;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_MUL: begin
					if (mm_done) begin
						acc_q   <= mm_r;
						state_q <= S_NEXT;
					end
				end
				S_PDONE: begin
					if (mode_q != MODE_CRT) begin
						res_q   <= VALUE_W'(acc_q);
						state_q <= S_FIN;
					end else if (!crt2_q) begin
						m1_q    <= acc_q[PRIME_W-1:0];
						crt2_q  <= 1'b1;
						mod_q   <= MW'(prime_second_q);
						exp_q   <= EXP_W'(dq_q);
						state_q <= S_PSTART;
					end else begin
						m2_q    <= acc_q[PRIME_W-1:0];
						mm_go_q <= 1'b1;
						mm_x_q  <= VALUE_W'(acc_q);
						mm_y_q  <= MW'(1);
						mm_m_q  <= MW'(prime_first_q);
						state_q <= S_RM2;
					end
				end
				S_RM2: begin
					if (mm_done) begin
						mm_go_q <= 1'b1;
						mm_x_q  <= VALUE_W'(qinv_q);
						mm_y_q  <= MW'(diff_wide[PRIME_W-1:0]);
						mm_m_q  <= MW'(prime_first_q);
						state_q <= S_HMUL;
					end
				end
				S_HMUL: begin
					if (mm_done) begin
						prod_q  <= VALUE_W'(mm_r[PRIME_W-1:0]) * VALUE_W'(prime_second_q);
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					res_q   <= VALUE_W'(m2_q) + prod_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						out_flag_q  <= flag_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_flag_q;

`include "assert_macros.svh"

	`ASSERT_PROP(a_flag_only_crt, clk, arst_n, (state_q == S_FIN && flag_q) |-> (mode_q == MODE_CRT && res_q == '0), "no-inverse flag outside CRT or with nonzero result")

endmodule

`default_nettype wire

// ===== tb/tb_rsa_modexp_crt_unit_top.sv =====
`timescale 1ns / 1ps

module tb_rsa_modexp_crt_unit_top;
	import rsamx_pkg::*;

	localparam int unsigned MOD_W = MOD_WIDTH_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 9000;

	typedef struct packed {
		logic [VALUE_W-1:0] result;
		logic               no_inverse;
	} modexp_word_t;

	class modexp_scoreboard;
		logic [CFG_W-1:0]   modulus;
		logic [EXP_W-1:0]   pub_exp;
		logic [EXP_W-1:0]   priv_exp;
		logic [PRIME_W-1:0] prime_p;
		logic [PRIME_W-1:0] prime_q;
		modexp_word_t       pending_results[$];
		int unsigned        mismatches;

		function new();
			modulus    = MODULUS_RST;
			pub_exp    = PUB_EXP_RST;
			priv_exp   = PRIV_EXP_RST;
			prime_p    = PRIME_FIRST_RST;
			prime_q    = PRIME_SECOND_RST;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_MODULUS:      modulus  = data;
				CFG_PUB_EXP:      pub_exp  = data;
				CFG_PRIV_EXP:     priv_exp = data;
				CFG_PRIME_FIRST:  prime_p  = data[PRIME_W-1:0];
				CFG_PRIME_SECOND: prime_q  = data[PRIME_W-1:0];
				default: ;
			endcase
		endfunction

		// Square-and-multiply from the top bit down; a zero exponent leaves the
		// accumulator at 1 without any reduction.
		function longint unsigned power_mod(longint unsigned base, logic [31:0] ex,
				longint unsigned m);
			longint unsigned acc;
			longint unsigned b;
			bit started;
			acc = 1;
			b = base % m;
			started = 0;
			for (int i = 31; i >= 0; i--) begin
				if (started)
					acc = (acc * acc) % m;
				if (ex[i]) begin
					acc = (acc * b) % m;
					started = 1;
				end
			end
			return acc;
		endfunction

		function bit inverse_mod(longint unsigned a, longint unsigned m,
				output longint unsigned inv);
			longint r0, r1, t0, t1, qt, rn, tn;
			r0 = longint'(m);
			r1 = longint'(a % m);
			t0 = 0;
			t1 = 1;
			inv = 0;
			while (r1 != 0) begin
				qt = r0 / r1;
				rn = r0 - qt * r1;
				tn = t0 - qt * t1;
				r0 = r1;
				r1 = rn;
				t0 = t1;
				t1 = tn;
			end
			if (r0 != 1)
				return 0;
			if (t0 < 0)
				t0 += longint'(m);
			inv = t0;
			return 1;
		endfunction

		function modexp_word_t predict_modexp(logic [1:0] mode, logic [VALUE_W-1:0] value);
			modexp_word_t o;
			longint unsigned n, p, q, qinv, dp, dq, m1, m2, diff, h, res;
			o = '0;
			res = 0;
			n = longint'(modulus) & ((64'd1 << MOD_W) - 1);
			case (mode)
				MODE_ENC: begin
					if (pub_exp == 0)
						res = 1;
					else if (n != 0)
						res = power_mod(value, pub_exp, n);
				end
				MODE_DEC: begin
					if (value == 0)
						res = 0;
					else if (priv_exp == 0)
						res = 1;
					else if (n != 0)
						res = power_mod(value, priv_exp, n);
				end
				MODE_CRT: begin
					p = prime_p;
					q = prime_q;
					if (value == 0)
						res = 0;
					else if (p < 2 || q < 2 || !inverse_mod(q, p, qinv))
						o.no_inverse = 1'b1;
					else begin
						dp = priv_exp % (p - 1);
						dq = priv_exp % (q - 1);
						m1 = power_mod(value, dp[31:0], p);
						m2 = power_mod(value, dq[31:0], q);
						diff = (m1 + p - (m2 % p)) % p;
						h = (qinv * diff) % p;
						res = m2 + h * q;
					end
				end
				default: ;
			endcase
			o.result = res[VALUE_W-1:0];
			return o;
		endfunction

		function void note_word(logic [1:0] mode, logic [VALUE_W-1:0] value);
			pending_results.push_back(predict_modexp(mode, value));
		endfunction

		function void check_word(logic [VALUE_W-1:0] result, logic no_inverse);
			modexp_word_t want;
			if (pending_results.size() == 0) begin
				$error("result word arrived with no prediction waiting: result %0d flag %0d",
					result, no_inverse);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (result !== want.result) begin
				$error("result: expected %0d, got %0d", want.result, result);
				mismatches++;
			end
			if (no_inverse !== want.no_inverse) begin
				$error("no_inverse: expected %0d, got %0d", want.no_inverse, no_inverse);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [VALUE_W-1:0]   s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [VALUE_W-1:0]   m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	modexp_scoreboard sb = new();
	bit calm_sender = 0;
	bit calm_receiver = 0;
	int unsigned words_out = 0;

	rsa_modexp_crt_unit_top #(
		.MOD_WIDTH(MOD_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Returns at the rising edge on which the word was taken, so the valid line is
	// only ever lowered at the following falling edge.
	task automatic send_word(input logic [1:0] mode, input logic [VALUE_W-1:0] value);
		int gap;
		gap = calm_sender ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(mode, value);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] n, input logic [EXP_W-1:0] e,
			input logic [EXP_W-1:0] d, input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] q);
		settle();
		write_reg(CFG_MODULUS, n);
		write_reg(CFG_PUB_EXP, e);
		write_reg(CFG_PRIV_EXP, d);
		write_reg(CFG_PRIME_FIRST, p);
		write_reg(CFG_PRIME_SECOND, q);
	endtask

	// A keyed setting uses two distinct primes and their product as the modulus; otherwise
	// every register takes arbitrary content. The upper prime bits are random in both cases.
	task automatic random_setting(input bit keyed);
		logic [PRIME_W-1:0] p, q;
		logic [CFG_W-1:0]   n;
		logic [EXP_W-1:0]   e, d;
		int k;
		if (keyed) begin
			k = $urandom_range(0, 9);
			case (k)
				0: p = 16'd2;      1: p = 16'd3;      2: p = 16'd61;    3: p = 16'd53;
				4: p = 16'd251;    5: p = 16'd257;    6: p = 16'd4093;  7: p = 16'd32749;
				8: p = 16'd65519;  default: p = 16'd65521;
			endcase
			case ((k + $urandom_range(1, 9)) % 10)
				0: q = 16'd2;      1: q = 16'd3;      2: q = 16'd61;    3: q = 16'd53;
				4: q = 16'd251;    5: q = 16'd257;    6: q = 16'd4093;  7: q = 16'd32749;
				8: q = 16'd65519;  default: q = 16'd65521;
			endcase
			n = {16'd0, p} * {16'd0, q};
		end else begin
			p = $urandom_range(0, 65535);
			q = ($urandom_range(0, 4) == 0) ? p : 16'($urandom_range(0, 65535));
			case ($urandom_range(0, 3))
				0: n = $urandom;
				1: n = $urandom_range(2, 65535);
				2: n = $urandom | 32'h8000_0000;
				default: n = $urandom_range(0, 3);
			endcase
		end
		e = $urandom >> $urandom_range(0, 31);
		d = $urandom >> $urandom_range(0, 31);
		write_all(n, e, d, {16'($urandom), p}, {16'($urandom), q});
	endtask

	task automatic send_random(input int count);
		logic [1:0]         mode;
		logic [VALUE_W-1:0] value;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				mode = MODE_ENC;
			else if (r < 6)
				mode = MODE_DEC;
			else if (r < 9)
				mode = MODE_CRT;
			else
				mode = MODE_UNUSED;
			case ($urandom_range(0, 7))
				0: value = '0;
				1: value = '1;
				2: value = $urandom_range(1, 255);
				3: value = (sb.modulus != 0) ? $urandom % sb.modulus : $urandom;
				default: value = $urandom;
			endcase
			send_word(mode, value);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Settings out of reset: a textbook key.
		send_word(MODE_ENC, 32'd65);
		send_word(MODE_ENC, 32'd0);
		send_word(MODE_ENC, 32'hFFFF_FFFF);
		send_word(MODE_DEC, 32'd2790);
		send_word(MODE_DEC, 32'd0);
		send_word(MODE_CRT, 32'd2790);
		send_word(MODE_CRT, 32'd0);
		send_word(MODE_CRT, 32'hFFFF_FFFF);
		send_word(MODE_UNUSED, 32'hA5A5_5A5A);

		// Zero exponents with a modulus of one still give 1, except a zero decrypt value, which gives 0.
		write_all(32'd1, 32'd0, 32'd0, 32'd61, 32'd53);
		send_word(MODE_ENC, 32'hFFFF_FFFF);
		send_word(MODE_DEC, 32'd7);
		send_word(MODE_DEC, 32'd0);
		send_word(MODE_CRT, 32'd12345);

		// Zero modulus, full exponents and equal primes.
		write_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd61, 32'd61);
		send_word(MODE_ENC, 32'd12);
		send_word(MODE_DEC, 32'd12);
		send_word(MODE_CRT, 32'd12);
		send_word(MODE_CRT, 32'd0);

		// Degenerate primes on either side.
		settle();
		write_reg(CFG_PRIME_FIRST, 32'd1);
		write_reg(CFG_PRIME_SECOND, 32'd53);
		send_word(MODE_CRT, 32'd99);
		settle();
		write_reg(CFG_PRIME_FIRST, 32'd61);
		write_reg(CFG_PRIME_SECOND, 32'd0);
		send_word(MODE_CRT, 32'd99);

		// Widest modulus and primes.
		write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535, 32'd65521);
		send_word(MODE_ENC, 32'hFFFF_FFFF);
		send_word(MODE_DEC, 32'hFFFF_FFFE);
		send_word(MODE_CRT, 32'hFFFF_FFFF);
		send_word(MODE_UNUSED, 32'hFFFF_FFFF);

		for (int ph = 0; ph < 6; ph++) begin
			random_setting(ph % 2 == 0);
			calm_sender = (ph % 3 == 1);
			calm_receiver = (ph % 3 == 2);
			send_random(41);
		end

		settle();
		repeat (3000) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side. One long hold-off in the middle of the first random run lets the
	// sender, still offering words, run into a full unit.
	initial begin
		int stall;
		bit held;
		held = 0;
		wait (arst_n);
		forever begin
			stall = calm_receiver ? 0 : $urandom_range(0, 16);
			if (!held && words_out == 40) begin
				stall = HOLD_CYCLES;
				held = 1;
			end
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_word(m_axis_tdata, m_axis_tuser);
			words_out++;
		end
	end

	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
